// ===== rtl/puhc_pkg.sv =====
// ----------------------------------------------------------------------------
// puhc_pkg
// Shared types and codes for the upload header checker: channel words,
// fault and verdict codes, register indexes and PNG header constants.
// ----------------------------------------------------------------------------
package puhc_pkg;

    // widths fixed by the field definitions
    localparam int unsigned COUNT_W  = 21;
    localparam int unsigned PIXEL_W  = 16;
    localparam int unsigned DIM_W    = 32;
    localparam int unsigned HDR_BYTES = 24;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int unsigned ADDR_W   = 3;

    // register reset values
    localparam logic [COUNT_W-1:0] MAX_UPLOAD_RESET = COUNT_W'(16384);
    localparam logic [PIXEL_W-1:0] MAX_PIXELS_RESET = PIXEL_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_SAT        = '1;

    // register indexes (word address bit)
    localparam logic REG_MAX_UPLOAD = 1'b0;
    localparam logic REG_MAX_PIXELS = 1'b1;

    // latched fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_SIZE = 2'd1;
    localparam logic [1:0] FAULT_READ = 2'd2;

    // verdict codes
    localparam logic [2:0] V_OK    = 3'd0;
    localparam logic [2:0] V_EMPTY = 3'd1;
    localparam logic [2:0] V_SIZE  = 3'd2;
    localparam logic [2:0] V_READ  = 3'd3;
    localparam logic [2:0] V_BAD   = 3'd4;

    // PNG signature followed by the IHDR tag at bytes 12 to 15
    localparam logic [7:0] PNG_SIG [12] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h49, 8'h48, 8'h44, 8'h52
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       source_fault;
        logic       end_of_upload;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         verdict;
        logic [COUNT_W-1:0] upload_length;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } out_word_t;

endpackage

// ===== rtl/png_upload_header_checker_top.sv =====
// ----------------------------------------------------------------------------
// png_upload_header_checker_top
// Counts upload bytes, keeps the first 24, latches the first fault and
// reports one verdict per upload (signature, IHDR tag and image size check).
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+------------
//   input   | s_valid s_ready s_data         | in        | in_word_t
//   result  | m_valid m_ready m_data         | out       | out_word_t
//   config  | psel penable pwrite paddr ...  | in/out    | 32-bit APB
//
// One input word is taken every cycle while s_ready is high; a closing word's
// result is registered in head, or in skid if head holds a result not taken.
// The cycle path is the count increment and compare against the cap, then
// the width and height compares feeding the verdict select.
// Two result registers (head and skid) let input flow while a result waits;
// s_ready drops only when both hold a result. Synchronous active-low reset
// clears count, fault and result valids; the header bytes are not reset.
// ----------------------------------------------------------------------------
module png_upload_header_checker_top
    import puhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [COUNT_W-1:0] max_upload_reg;
    logic [PIXEL_W-1:0] max_pixels_reg;
    logic [COUNT_W-1:0] byte_total_reg, byte_total_next;
    logic [1:0]         fault_reg, fault_next;
    logic [7:0]         hdr_reg  [HDR_BYTES];
    logic [7:0]         hdr_next [HDR_BYTES];

    logic               s_accept;
    logic               take_byte;
    logic [COUNT_W:0]   count_inc;
    logic [COUNT_W:0]   count_limit;
    logic               hdr_open;
    logic               full_hdr;
    logic               sig_ok;
    logic [DIM_W-1:0]   width_w, height_w;
    logic               size_ok;
    out_word_t          result;

    out_word_t          head_reg, head_next;
    out_word_t          skid_reg, skid_next;
    logic               head_valid_reg, head_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               push, pop;

    // configuration port
    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == REG_MAX_PIXELS) begin
            prdata = {{(32-PIXEL_W){1'b0}}, max_pixels_reg};
        end else begin
            prdata = {{(32-COUNT_W){1'b0}}, max_upload_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_upload_reg <= MAX_UPLOAD_RESET;
            max_pixels_reg <= MAX_PIXELS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_PIXELS) begin
                max_pixels_reg <= pwdata[PIXEL_W-1:0];
            end else begin
                max_upload_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // byte count and fault latch
    assign s_accept  = s_valid && s_ready;
    assign take_byte = s_accept && (fault_reg == FAULT_NONE) && !s_data.source_fault
                       && s_data.has_byte;
    assign count_inc   = {1'b0, byte_total_reg} + (COUNT_W+1)'(1);
    assign count_limit = {1'b0, max_upload_reg} + (COUNT_W+1)'(1);
    assign hdr_open    = byte_total_reg < COUNT_W'(HDR_BYTES);

    always_comb begin
        byte_total_next = byte_total_reg;
        fault_next      = fault_reg;
        if (s_accept && (fault_reg == FAULT_NONE)) begin
            if (s_data.source_fault) begin
                fault_next = FAULT_READ;
            end else if (s_data.has_byte) begin
                if (count_inc > {1'b0, max_upload_reg}) begin
                    fault_next = FAULT_SIZE;
                    if (count_limit[COUNT_W]) begin
                        byte_total_next = COUNT_SAT;
                    end else begin
                        byte_total_next = count_limit[COUNT_W-1:0];
                    end
                end else begin
                    byte_total_next = count_inc[COUNT_W-1:0];
                end
            end
        end
    end

    // header bytes, with this word's byte merged in
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (take_byte && hdr_open
                && (byte_total_reg[HDR_IDX_W-1:0] == HDR_IDX_W'(i))) begin
                hdr_next[i] = s_data.data_byte;
            end else begin
                hdr_next[i] = hdr_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_reg[i] <= hdr_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg <= '0;
            fault_reg      <= FAULT_NONE;
        end else if (s_accept && s_data.end_of_upload) begin
            byte_total_reg <= '0;
            fault_reg      <= FAULT_NONE;
        end else begin
            byte_total_reg <= byte_total_next;
            fault_reg      <= fault_next;
        end
    end

    // header checks on the updated state
    assign full_hdr = byte_total_next >= COUNT_W'(HDR_BYTES);

    always_comb begin
        sig_ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (hdr_next[i] != PNG_SIG[i]) begin
                sig_ok = 1'b0;
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (hdr_next[12+i] != PNG_SIG[8+i]) begin
                sig_ok = 1'b0;
            end
        end
    end

    assign width_w  = full_hdr ? {hdr_next[16], hdr_next[17], hdr_next[18], hdr_next[19]}
                               : '0;
    assign height_w = full_hdr ? {hdr_next[20], hdr_next[21], hdr_next[22], hdr_next[23]}
                               : '0;
    assign size_ok  = (width_w != '0) && (height_w != '0)
                      && (width_w <= {{(DIM_W-PIXEL_W){1'b0}}, max_pixels_reg})
                      && (height_w <= {{(DIM_W-PIXEL_W){1'b0}}, max_pixels_reg});

    // verdict select
    always_comb begin
        result.upload_length = byte_total_next;
        result.image_width   = width_w;
        result.image_height  = height_w;
        if (fault_next == FAULT_READ) begin
            result.verdict = V_READ;
        end else if (fault_next != FAULT_NONE) begin
            result.verdict = V_SIZE;
        end else if (byte_total_next == '0) begin
            result.verdict = V_EMPTY;
        end else if (!full_hdr || !sig_ok || !size_ok) begin
            result.verdict = V_BAD;
        end else begin
            result.verdict = V_OK;
        end
    end

    // result head and skid registers
    assign push    = s_accept && s_data.end_of_upload;
    assign pop     = head_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!head_valid_reg || pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_next       = result;
                skid_valid_next = push;
            end else begin
                head_next       = result;
                head_valid_next = push;
            end
        end else if (push) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // checks
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid holds a result while head is empty");

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.end_of_upload) |=> (byte_total_reg == '0 && fault_reg == FAULT_NONE))
        else $error("upload state not cleared after verdict");

    a_size_fault_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fault_reg == FAULT_SIZE) |-> (byte_total_reg != '0))
        else $error("size fault latched with zero byte count");

    a_result_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.end_of_upload && !m_valid) |=> m_valid)
        else $error("closing word produced no result");

endmodule
